[design/swd_pkg.sv]
package swd_pkg;

	localparam int unsigned POS_W   = 32;
	localparam int unsigned REG_W   = 20;
	localparam int unsigned CNT_W   = 21;
	localparam int unsigned PHASE_W = 3;
	localparam int unsigned PINS_W  = 4;

	localparam logic [PHASE_W-1:0] PHASE_OFF   = 3'd0;
	localparam logic [PHASE_W-1:0] PHASE_FIRST = 3'd1;
	localparam logic [PHASE_W-1:0] PHASE_LAST  = 3'd4;

	localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

	localparam logic [REG_W-1:0] STEP_INTERVAL_RST = 20'd2000;
	localparam logic [REG_W-1:0] COIL_OFF_TIME_RST = 20'd1000;

	typedef enum logic [2:0] {
		MODE_TICK      = 3'd0,
		MODE_GOTO      = 3'd1,
		MODE_FORWARD   = 3'd2,
		MODE_REVERSE   = 3'd3,
		MODE_STOP      = 3'd4,
		MODE_RESET_POS = 3'd5
	} mode_t;

	typedef enum logic [1:0] {
		MOVE_GOTO    = 2'd0,
		MOVE_FORWARD = 2'd1,
		MOVE_REVERSE = 2'd2
	} move_t;

	localparam logic CFG_STEP_INTERVAL = 1'b0;
	localparam logic CFG_COIL_OFF_TIME = 1'b1;

	typedef struct packed {
		logic [REG_W-1:0] step_interval;
		logic [REG_W-1:0] coil_off_time;
	} cfg_t;

	typedef struct packed {
		logic [POS_W-1:0]   position;
		logic [POS_W-1:0]   target;
		logic [1:0]         move_mode;
		logic [CNT_W-1:0]   since_step;
		logic [PHASE_W-1:0] phase;
		logic               coils_on;
		logic [CNT_W-1:0]   since_coil;
		logic [PINS_W-1:0]  pins;
	} motor_state_t;

	typedef struct packed {
		logic [PINS_W-1:0] coil_pins;
		logic [POS_W-1:0]  position;
		logic              moving;
		logic              stepped;
	} result_t;

	// phase table: phases 1 and 2 energize one winding, phases 3 and 4 two; other phases none
	function automatic logic [PINS_W-1:0] wave_pins(input logic [PHASE_W-1:0] ph);
		logic [PINS_W-1:0] p;
		case (ph)
			3'd1:    p = 4'h4;
			3'd2:    p = 4'h1;
			3'd3:    p = 4'hC;
			3'd4:    p = 4'h3;
			default: p = 4'h0;
		endcase
		return p;
	endfunction

	function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
		return (c == CNT_MAX) ? c : c + 1'b1;
	endfunction

endpackage

[design/swd_cfg_regs.sv]
module swd_cfg_regs (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic                     cfg_index,
	input  logic [swd_pkg::REG_W-1:0] cfg_wdata,
	output swd_pkg::cfg_t            cfg
);

	swd_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.step_interval <= swd_pkg::STEP_INTERVAL_RST;
			cfg_q.coil_off_time <= swd_pkg::COIL_OFF_TIME_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				swd_pkg::CFG_STEP_INTERVAL: cfg_q.step_interval <= cfg_wdata;
				swd_pkg::CFG_COIL_OFF_TIME: cfg_q.coil_off_time <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

[design/swd_step_logic.sv]
module swd_step_logic (
	input  swd_pkg::cfg_t                cfg,
	input  swd_pkg::motor_state_t        cur,
	input  logic [2:0]                   mode,
	input  logic [swd_pkg::POS_W-1:0]    target_value,
	output swd_pkg::motor_state_t        nxt,
	output swd_pkg::result_t             res
);

	logic [swd_pkg::CNT_W-1:0]   sls_inc;
	logic [swd_pkg::CNT_W-1:0]   sco_inc;
	logic [swd_pkg::CNT_W-1:0]   interval_ext;
	logic [swd_pkg::CNT_W-1:0]   off_ext;
	logic                        mv_fwd;
	logic                        mv_rev;
	logic                        due;
	logic                        shall;
	logic                        dir_fwd;
	logic                        step;
	logic                        stepped_c;
	logic [swd_pkg::PHASE_W-1:0] ph_fwd;
	logic [swd_pkg::PHASE_W-1:0] ph_rev;
	logic [swd_pkg::PHASE_W-1:0] ph_new;

	assign sls_inc      = swd_pkg::sat_inc(cur.since_step);
	assign sco_inc      = swd_pkg::sat_inc(cur.since_coil);
	assign interval_ext = {1'b0, cfg.step_interval};
	assign off_ext      = {1'b0, cfg.coil_off_time};

	// movement code 3 falls to goto
	assign mv_fwd  = (cur.move_mode == swd_pkg::MOVE_FORWARD);
	assign mv_rev  = (cur.move_mode == swd_pkg::MOVE_REVERSE);
	assign due     = (sls_inc > interval_ext);
	assign shall   = mv_fwd | mv_rev | (cur.target != cur.position);
	assign dir_fwd = mv_fwd | (!mv_rev && ($signed(cur.target) > $signed(cur.position)));
	assign step    = due & shall;

	assign ph_fwd = (cur.phase >= swd_pkg::PHASE_LAST) ? swd_pkg::PHASE_FIRST
	                                                   : cur.phase + 1'b1;
	assign ph_rev = (cur.phase <= swd_pkg::PHASE_FIRST || cur.phase > swd_pkg::PHASE_LAST)
	                ? swd_pkg::PHASE_LAST : cur.phase - 1'b1;
	assign ph_new = dir_fwd ? ph_fwd : ph_rev;

	always_comb begin
		nxt       = cur;
		stepped_c = 1'b0;
		unique case (mode)
			swd_pkg::MODE_TICK: begin
				nxt.since_step = sls_inc;
				nxt.since_coil = sco_inc;
				if (step) begin
					nxt.position   = dir_fwd ? cur.position + 1'b1 : cur.position - 1'b1;
					nxt.phase      = ph_new;
					nxt.pins       = swd_pkg::wave_pins(ph_new);
					nxt.coils_on   = 1'b1;
					nxt.since_step = '0;
					nxt.since_coil = '0;
					stepped_c      = 1'b1;
				end else begin
					if (due) begin
						nxt.since_step = interval_ext;
					end
					if (cur.coils_on && sco_inc > off_ext) begin
						nxt.pins     = '0;
						nxt.coils_on = 1'b0;
					end
				end
			end
			swd_pkg::MODE_GOTO: begin
				nxt.move_mode = swd_pkg::MOVE_GOTO;
				nxt.target    = target_value;
			end
			swd_pkg::MODE_FORWARD: begin
				nxt.move_mode = swd_pkg::MOVE_FORWARD;
			end
			swd_pkg::MODE_REVERSE: begin
				nxt.move_mode = swd_pkg::MOVE_REVERSE;
			end
			swd_pkg::MODE_STOP: begin
				nxt.pins      = '0;
				nxt.coils_on  = 1'b0;
				nxt.move_mode = swd_pkg::MOVE_GOTO;
				nxt.target    = cur.position;
			end
			swd_pkg::MODE_RESET_POS: begin
				nxt.move_mode = swd_pkg::MOVE_GOTO;
				nxt.position  = target_value;
				nxt.target    = target_value;
			end
			default: ;
		endcase
	end

	assign res.coil_pins = nxt.pins;
	assign res.position  = nxt.position;
	assign res.stepped   = stepped_c;
	assign res.moving    = !((nxt.move_mode != swd_pkg::MOVE_FORWARD)
	                         && (nxt.move_mode != swd_pkg::MOVE_REVERSE)
	                         && (nxt.target == nxt.position)
	                         && (nxt.since_step <= interval_ext));

endmodule

[design/stepper_wave_drive_controller_unit.sv]
// Channel  | Handshake            | Payload
// -------- | -------------------- | ------------------------------------------
// in       | in_valid / in_stall  | mode[2:0], target_value[31:0] signed
// out      | out_valid / out_stall| coil_pins[3:0], position[31:0], moving, stepped
// cfg      | cfg_we               | cfg_index (0 step_interval, 1 coil_off_time), cfg_wdata[19:0]
//
// One request per cycle while out_stall is low; out_valid rises when the result reaches stage 2.
// Stage 1 holds the accepted request; the motor state is updated and the result
// registered as it moves into stage 2, so each request sees its predecessor's state.
// in_stall rises only when both stages are full and out_stall holds stage 2.
// arst_n clears the valid bits, the motor state and loads the register defaults.
module stepper_wave_drive_controller_unit (
	input  logic        clk,
	input  logic        arst_n,

	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  mode,
	input  logic signed [31:0] target_value,

	output logic        out_valid,
	input  logic        out_stall,
	output logic [3:0]  coil_pins,
	output logic signed [31:0] position,
	output logic        moving,
	output logic        stepped,

	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [19:0] cfg_wdata
);

	swd_pkg::cfg_t         cfg;
	swd_pkg::motor_state_t state_q;
	swd_pkg::motor_state_t state_nxt;
	swd_pkg::result_t      res_nxt;

	// stage 1: request register
	logic                        valid_s1;
	logic [2:0]                  mode_s1;
	logic [swd_pkg::POS_W-1:0]   target_s1;

	// stage 2: result register
	logic                        valid_s2;
	swd_pkg::result_t            res_s2;

	logic adv_s2;   // stage 2 can take a new result
	logic adv_s1;   // stage 1 request retires into stage 2
	logic take_in;

	assign adv_s2   = !valid_s2 || !out_stall;
	assign adv_s1   = valid_s1 && adv_s2;
	assign in_stall = valid_s1 && !adv_s2;
	assign take_in  = in_valid && !in_stall;

	swd_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	swd_step_logic u_step (
		.cfg          (cfg),
		.cur          (state_q),
		.mode         (mode_s1),
		.target_value (target_s1),
		.nxt          (state_nxt),
		.res          (res_nxt)
	);

	// request stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take_in) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			mode_s1   <= mode;
			target_s1 <= target_value;
		end
	end

	// motor state commits only when the request retires
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (adv_s1) begin
			state_q <= state_nxt;
		end
	end

	// result stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			res_s2 <= res_nxt;
		end
	end

	assign out_valid = valid_s2;
	assign coil_pins = res_s2.coil_pins;
	assign position  = res_s2.position;
	assign moving    = res_s2.moving;
	assign stepped   = res_s2.stepped;

endmodule
